@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define SBDA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SBDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/sbda_pkg.sv @@
// Constants and helpers for the signed binary to decimal ASCII converter.
package sbda_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int DIGIT_W             = 4;
    localparam int CHAR_W              = 6;
    localparam int BYTE_W              = 8;

    localparam logic [CHAR_W-1:0]  CH_ZERO     = 6'd48;
    localparam logic [CHAR_W-1:0]  CH_MINUS    = 6'd45;
    localparam logic [DIGIT_W-1:0] BCD_FIX_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_FIX_ADD = 4'd3;

    // Decimal digits of 2^(w-1), the largest magnitude; log10(2) ~ 0.30103
    function automatic int num_digits(input int w);
        return ((w - 1) * 30103) / 100000 + 1;
    endfunction

    // Bus width rounded up to whole bytes
    function automatic int byte_round(input int w);
        return ((w + BYTE_W - 1) / BYTE_W) * BYTE_W;
    endfunction

endpackage

@@ sv/signed_binary_to_decimal_ascii.sv @@
// Top level of the signed binary to decimal ASCII converter.
//
//  Channel | Direction | Payload
//  --------+-----------+------------------------------------------------
//  s_      | in        | tdata: value (signed, VALUE_WIDTH bits)
//  m_      | out       | tdata: char_code (6 bits); tlast: last character
//
// A request closes s_tready while the value is shifted in with add-3 correction,
// one input bit per cycle, and while the result waits for handover, which waits
// while the emitter is still busy. The emitter then takes one digit position per
// cycle (leading zeros skipped one per cycle), after a minus sign if negative,
// stalling while a character waits on m_tready; the next value converts meanwhile.
// aresetn is synchronous, active low, and empties both stages.
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [byte_round(VALUE_WIDTH)-1:0] s_tdata,  // [VALUE_WIDTH-1:0] value
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [BYTE_W-1:0]                  m_tdata,  // [5:0] char_code, zero fill
    output logic                               m_tlast
);

    localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);

    logic                          hand_valid;
    logic                          hand_ready;
    logic                          hand_neg;
    logic [NUM_DIGITS*DIGIT_W-1:0] hand_bcd;
    logic [CHAR_W-1:0]             out_char;

    // Binary to BCD, one bit per cycle
    sbda_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_dabble (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata[VALUE_WIDTH-1:0]),
        .hand_valid (hand_valid),
        .hand_ready (hand_ready),
        .hand_neg   (hand_neg),
        .hand_bcd   (hand_bcd)
    );

    // BCD digits to ASCII characters
    sbda_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .hand_valid (hand_valid),
        .hand_ready (hand_ready),
        .hand_neg   (hand_neg),
        .hand_bcd   (hand_bcd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (out_char),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(BYTE_W-CHAR_W){1'b0}}, out_char};

endmodule

@@ sv/sbda_dabble.sv @@
// Bit-serial binary to BCD conversion (shift and add-3), one input bit per cycle.
module sbda_dabble
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
    parameter int NUM_DIGITS  = num_digits(VALUE_WIDTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input request
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [VALUE_WIDTH-1:0]        in_value,
    // handover to the character emitter
    output logic                          hand_valid,
    input  logic                          hand_ready,
    output logic                          hand_neg,
    output logic [NUM_DIGITS*DIGIT_W-1:0] hand_bcd
);

    localparam int BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic [BCD_W-1:0]       bcd_fixed;
    logic                   in_fire;

    assign in_ready = !busy_reg && !done_reg;
    assign in_fire  = in_valid && in_ready;

    // Add 3 to every digit of five or more ahead of the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] >= BCD_FIX_MIN) begin
                bcd_fixed[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W] + BCD_FIX_ADD;
            end else begin
                bcd_fixed[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Load, shift and handover control
    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        if (in_fire) begin
            neg_next  = in_value[VALUE_WIDTH-1];
            mag_next  = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {bcd_fixed[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next = mag_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (done_reg && hand_ready) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign hand_valid = done_reg;
    assign hand_neg   = neg_reg;
    assign hand_bcd   = bcd_reg;

endmodule

@@ sv/sbda_emit.sv @@
// Character emitter: walks the BCD digits from the top, drops leading zeros.
module sbda_emit
    import sbda_pkg::*;
#(
    parameter int NUM_DIGITS = num_digits(DEFAULT_VALUE_WIDTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // handover from the converter
    input  logic                          hand_valid,
    output logic                          hand_ready,
    input  logic                          hand_neg,
    input  logic [NUM_DIGITS*DIGIT_W-1:0] hand_bcd,
    // character output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [CHAR_W-1:0]             out_char,
    output logic                          out_last
);

    localparam int BCD_W  = NUM_DIGITS * DIGIT_W;
    localparam int LEFT_W = $clog2(NUM_DIGITS + 1);

    logic               active_reg, active_next;
    logic               sign_reg, sign_next;
    logic               started_reg, started_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic [BCD_W-1:0]   dig_reg, dig_next;
    logic               ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]  ochar_reg, ochar_next;
    logic               olast_reg, olast_next;

    logic [DIGIT_W-1:0] top_digit;
    logic               is_final;
    logic               skip;
    logic               slot_free;

    assign top_digit  = dig_reg[BCD_W-1 -: DIGIT_W];
    assign is_final   = (left_reg == LEFT_W'(1));
    assign skip       = !sign_reg && !started_reg && !is_final && (top_digit == '0);
    assign slot_free  = !ovalid_reg || out_ready;
    assign hand_ready = !active_reg;

    // One digit position per cycle unless a character waits on out_ready; sign first, leading zeros dropped
    always_comb begin
        active_next  = active_reg;
        sign_next    = sign_reg;
        started_next = started_reg;
        left_next    = left_reg;
        dig_next     = dig_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        ochar_next   = ochar_reg;
        olast_next   = olast_reg;
        if (!active_reg) begin
            if (hand_valid) begin
                active_next  = 1'b1;
                sign_next    = hand_neg;
                started_next = 1'b0;
                left_next    = LEFT_W'(NUM_DIGITS);
                dig_next     = hand_bcd;
            end
        end else if (skip) begin
            dig_next  = dig_reg << DIGIT_W;
            left_next = left_reg - 1'b1;
        end else if (slot_free) begin
            ovalid_next = 1'b1;
            if (sign_reg) begin
                ochar_next = CH_MINUS;
                olast_next = 1'b0;
                sign_next  = 1'b0;
            end else begin
                ochar_next   = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                olast_next   = is_final;
                started_next = 1'b1;
                dig_next     = dig_reg << DIGIT_W;
                left_next    = left_reg - 1'b1;
                if (is_final) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
        sign_reg    <= sign_next;
        started_reg <= started_next;
        left_reg    <= left_next;
        dig_reg     <= dig_next;
        ochar_reg   <= ochar_next;
        olast_reg   <= olast_next;
    end

    assign out_valid = ovalid_reg;
    assign out_char  = ochar_reg;
    assign out_last  = olast_reg;

endmodule

@@ sv/sbda_checker.sv @@
// Port-level checks for the converter, bound to the top level.
`include "assert_macros.svh"

module sbda_checker
    import sbda_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tlast
);

    localparam logic [BYTE_W-1:0] CODE_MINUS = BYTE_W'(CH_MINUS);
    localparam logic [BYTE_W-1:0] CODE_ZERO  = BYTE_W'(CH_ZERO);
    localparam logic [BYTE_W-1:0] CODE_NINE  = CODE_ZERO + BYTE_W'(9);

    logic [BYTE_W:0] m_word;
    logic            stalled;
    logic            is_minus;
    logic            is_digit;

    assign m_word   = {m_tlast, m_tdata};
    assign stalled  = m_tvalid && !m_tready;
    assign is_minus = (m_tdata == CODE_MINUS);
    assign is_digit = (m_tdata >= CODE_ZERO) && (m_tdata <= CODE_NINE);

    // A stalled character holds
    `SBDA_ASSERT(a_hold, aclk, aresetn, stalled |=> m_tvalid && $stable(m_word), "held char changed")

    // Only a minus sign or a decimal digit is ever shown
    `SBDA_ASSERT(a_legal, aclk, aresetn, m_tvalid |-> is_minus || is_digit, "illegal character code")

    // A minus sign is never the final character
    `SBDA_ASSERT(a_sign, aclk, aresetn, m_tvalid && is_minus |-> !m_tlast, "minus sign flagged last")

    // A request starts a bit-serial conversion, so the input closes
    `SBDA_ASSERT(a_busy, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "reopened too soon")

    // Reset leaves no character pending
    `SBDA_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_tvalid, "character valid after reset")

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
